// ===== src/btpc_pkg.sv =====
`timescale 1ns / 1ps

package btpc_pkg;

  // Field widths of the stream items and the registers.
  localparam int POS_W    = 32;
  localparam int TEN_W    = 16;
  localparam int FRAC_W   = 12;
  localparam int GAIN_W   = 24;
  localparam int OFFS_W   = 21;
  localparam int MARGIN_W = 16;
  localparam int DIR_W    = 4;
  localparam int SUM_W    = 32;
  localparam int OUT_W    = 32;

  // Configuration port geometry.
  localparam int NUM_REGS = 7;
  localparam int DATA_W   = 32;
  localparam int ADDR_W   = 5;

  // Stream payload widths, padded to whole bytes.
  localparam int IN_DATA_W  = ((4 * POS_W + 4 * TEN_W + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((4 * OUT_W + 7) / 8) * 8;

  // Internal arithmetic widths.
  localparam int ERR_W  = ((TEN_W > MARGIN_W) ? TEN_W : MARGIN_W) + 1;
  localparam int HALF_W = POS_W + 1;
  localparam int PROD_W = GAIN_W + ((SUM_W > HALF_W) ? SUM_W : HALF_W);
  localparam int ACC_W  = PROD_W + 3;

  // Register map, one word per register.
  typedef enum logic [ADDR_W-3:0] {
    REG_PROP_GAIN   = 3'd0,
    REG_INTEG_GAIN  = 3'd1,
    REG_DERIV_GAIN  = 3'd2,
    REG_FOLLOW_GAIN = 3'd3,
    REG_PULL_OFFSET = 3'd4,
    REG_TEN_MARGIN  = 3'd5,
    REG_DIRECTION   = 3'd6
  } reg_idx_t;

  // Bit of each motor in the direction register.
  localparam int DIR_M1 = 0;
  localparam int DIR_M2 = 1;
  localparam int DIR_S1 = 2;
  localparam int DIR_S2 = 3;

endpackage

// ===== src/bilateral_tension_pid_controller.sv =====
`timescale 1ns / 1ps

// Channel     | Dir | Transaction
// ------------+-----+-----------------------------------------------------------
// s_*         | in  | one control tick: four positions, four tensions
// m_*         | out | four position commands (none for the first tick)
// APB         | in  | seven configuration registers at byte address 4*index
//
// A tick can be accepted in every cycle while s_tready is high. Its command set passes
// through five registers (input, PID error and integrator, products, sums, scaling and
// saturation) before it leaves on m_*.
// The first tick after reset only records home positions and tensions.
// Reset clears the start flag, the integrators, the configuration and the valid bits.
// A stage holds while the next is full and stalled; s_tready falls only when all five are full.
module bilateral_tension_pid_controller (
  input  logic                                clk,
  input  logic                                rst,
  // Tick input
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // pos_master_one, pos_master_two, pos_slave_one, pos_slave_two,
  // ten_master_one, ten_master_two, ten_slave_one, ten_slave_two
  input  logic [btpc_pkg::IN_DATA_W-1:0]      s_tdata,
  // Command output
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // cmd_master_one, cmd_master_two, cmd_slave_one, cmd_slave_two
  output logic [btpc_pkg::OUT_DATA_W-1:0]     m_tdata,
  // Configuration port
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [btpc_pkg::ADDR_W-1:0]         paddr,
  input  logic [btpc_pkg::DATA_W-1:0]         pwdata,
  output logic [btpc_pkg::DATA_W-1:0]         prdata,
  output logic                                pready
);

  localparam int POS_W  = btpc_pkg::POS_W;
  localparam int TEN_W  = btpc_pkg::TEN_W;
  localparam int FRAC_W = btpc_pkg::FRAC_W;
  localparam int GAIN_W = btpc_pkg::GAIN_W;
  localparam int OFFS_W = btpc_pkg::OFFS_W;
  localparam int MRG_W  = btpc_pkg::MARGIN_W;
  localparam int DIR_W  = btpc_pkg::DIR_W;
  localparam int SUM_W  = btpc_pkg::SUM_W;
  localparam int OUT_W  = btpc_pkg::OUT_W;
  localparam int DATA_W = btpc_pkg::DATA_W;
  localparam int ERR_W  = btpc_pkg::ERR_W;
  localparam int HALF_W = btpc_pkg::HALF_W;
  localparam int PROD_W = btpc_pkg::PROD_W;
  localparam int ACC_W  = btpc_pkg::ACC_W;
  localparam int FIN_W  = ACC_W + 1;

  // Configuration registers
  logic signed [GAIN_W-1:0] prop_gain;
  logic signed [GAIN_W-1:0] integ_gain_dt;
  logic signed [GAIN_W-1:0] deriv_gain_over_dt;
  logic signed [GAIN_W-1:0] follow_gain;
  logic signed [OFFS_W-1:0] pull_offset;
  logic signed [MRG_W-1:0]  margin_ten;
  logic        [DIR_W-1:0]  direction_bits;

  btpc_pkg::reg_idx_t reg_idx;
  logic               cfg_write;

  assign pready    = 1'b1;
  assign reg_idx   = btpc_pkg::reg_idx_t'(paddr[btpc_pkg::ADDR_W-1:2]);
  assign cfg_write = psel && penable && pwrite && pready;

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      prop_gain          <= '0;
      integ_gain_dt      <= '0;
      deriv_gain_over_dt <= '0;
      follow_gain        <= '0;
      pull_offset        <= '0;
      margin_ten         <= '0;
      direction_bits     <= '0;
    end else if (cfg_write) begin
      unique case (reg_idx)
        btpc_pkg::REG_PROP_GAIN:   prop_gain          <= pwdata[GAIN_W-1:0];
        btpc_pkg::REG_INTEG_GAIN:  integ_gain_dt      <= pwdata[GAIN_W-1:0];
        btpc_pkg::REG_DERIV_GAIN:  deriv_gain_over_dt <= pwdata[GAIN_W-1:0];
        btpc_pkg::REG_FOLLOW_GAIN: follow_gain        <= pwdata[GAIN_W-1:0];
        btpc_pkg::REG_PULL_OFFSET: pull_offset        <= pwdata[OFFS_W-1:0];
        btpc_pkg::REG_TEN_MARGIN:  margin_ten         <= pwdata[MRG_W-1:0];
        btpc_pkg::REG_DIRECTION:   direction_bits     <= pwdata[DIR_W-1:0];
        default: ;
      endcase
    end
  end

  // Register reads
  always_comb begin
    unique case (reg_idx)
      btpc_pkg::REG_PROP_GAIN:   prdata = DATA_W'(unsigned'(prop_gain));
      btpc_pkg::REG_INTEG_GAIN:  prdata = DATA_W'(unsigned'(integ_gain_dt));
      btpc_pkg::REG_DERIV_GAIN:  prdata = DATA_W'(unsigned'(deriv_gain_over_dt));
      btpc_pkg::REG_FOLLOW_GAIN: prdata = DATA_W'(unsigned'(follow_gain));
      btpc_pkg::REG_PULL_OFFSET: prdata = DATA_W'(unsigned'(pull_offset));
      btpc_pkg::REG_TEN_MARGIN:  prdata = DATA_W'(unsigned'(margin_ten));
      btpc_pkg::REG_DIRECTION:   prdata = DATA_W'(direction_bits);
      default:                   prdata = '0;
    endcase
  end

  // Pipeline valid bits and per-stage ready chain
  logic v1, v2, v3, v4, v5;
  logic rdy2, rdy3, rdy4, rdy5;

  assign rdy5     = !v5 || m_tready;
  assign rdy4     = !v4 || rdy5;
  assign rdy3     = !v3 || rdy4;
  assign rdy2     = !v2 || rdy3;
  assign s_tready = !v1 || rdy2;
  assign m_tvalid = v5;

  // Controller state
  logic                    started;
  logic signed [POS_W-1:0] home_pos [4];
  logic signed [TEN_W-1:0] last_ten [2];
  logic signed [SUM_W-1:0] err_sum  [2];

  // Stage 1: registered tick
  logic signed [POS_W-1:0] pos1 [4];
  logic signed [TEN_W-1:0] ten1 [4];

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (s_tready) begin
      v1 <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      for (int i = 0; i < 4; i++) begin
        pos1[i] <= s_tdata[i*POS_W +: POS_W];
        ten1[i] <= s_tdata[4*POS_W + i*TEN_W +: TEN_W];
      end
    end
  end

  // Stage 2 logic: targets, errors, integrators and the master difference
  logic                     take1;
  logic                     m1_lower;
  logic signed [ERR_W-1:0]  tgt      [2];
  logic signed [ERR_W-1:0]  err_c    [2];
  logic signed [ERR_W-1:0]  dten_c   [2];
  logic signed [SUM_W:0]    sum_ext  [2];
  logic signed [SUM_W-1:0]  sum_c    [2];
  logic signed [POS_W:0]    disp     [2];
  logic signed [POS_W:0]    pm       [2];
  logic signed [POS_W+1:0]  pm_diff;
  logic signed [POS_W+1:0]  pm_half;
  logic signed [HALF_W-1:0] half_c;

  assign take1    = v1 && rdy2;
  assign m1_lower = ten1[0] < ten1[1];

  always_comb begin
    // The lower-tension master pulls to the margin; the other tracks a slave.
    tgt[0] = m1_lower ? ERR_W'(margin_ten) : ERR_W'(ten1[3]);
    tgt[1] = m1_lower ? ERR_W'(ten1[2]) : ERR_W'(margin_ten);
    for (int c = 0; c < 2; c++) begin
      err_c[c]   = tgt[c] - ERR_W'(ten1[c]);
      dten_c[c]  = ERR_W'(ten1[c]) - ERR_W'(last_ten[c]);
      sum_ext[c] = (SUM_W+1)'(err_sum[c]) + (SUM_W+1)'(err_c[c]);
      // Saturate the integrator when the add carries into the extra bit.
      if (sum_ext[c][SUM_W] != sum_ext[c][SUM_W-1]) begin
        sum_c[c] = sum_ext[c][SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}}
                                     : {1'b0, {(SUM_W-1){1'b1}}};
      end else begin
        sum_c[c] = sum_ext[c][SUM_W-1:0];
      end
      disp[c] = (POS_W+1)'(pos1[c]) - (POS_W+1)'(home_pos[c]);
      pm[c]   = direction_bits[c] ? -disp[c] : disp[c];
    end
    // Halve the master difference, rounding toward zero.
    pm_diff = (POS_W+2)'(pm[0]) - (POS_W+2)'(pm[1]);
    pm_half = pm_diff[POS_W+1] ? ((pm_diff + (POS_W+2)'(1)) >>> 1) : (pm_diff >>> 1);
    half_c  = pm_half[HALF_W-1:0];
  end

  // State update, in tick order, as each tick leaves stage 1
  always_ff @(posedge clk) begin
    if (rst) begin
      started    <= 1'b0;
      err_sum[0] <= '0;
      err_sum[1] <= '0;
    end else if (take1) begin
      started <= 1'b1;
      if (started) begin
        err_sum[0] <= sum_c[0];
        err_sum[1] <= sum_c[1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take1) begin
      last_ten[0] <= ten1[0];
      last_ten[1] <= ten1[1];
      if (!started) begin
        for (int i = 0; i < 4; i++) begin
          home_pos[i] <= pos1[i];
        end
      end
    end
  end

  // Stage 2 registers; the capture tick is dropped here
  logic signed [ERR_W-1:0]  err2  [2];
  logic signed [ERR_W-1:0]  dten2 [2];
  logic signed [SUM_W-1:0]  sum2  [2];
  logic signed [HALF_W-1:0] half2 [2];
  logic signed [POS_W-1:0]  pos2  [2];

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (rdy2) begin
      v2 <= v1 && started;
    end
  end

  always_ff @(posedge clk) begin
    if (take1) begin
      for (int c = 0; c < 2; c++) begin
        err2[c]  <= err_c[c];
        dten2[c] <= dten_c[c];
        sum2[c]  <= sum_c[c];
        pos2[c]  <= pos1[c];
      end
      half2[0] <= half_c;
      half2[1] <= -half_c;
    end
  end

  // Stage 3: gain products
  logic signed [GAIN_W+ERR_W-1:0]  prod_p [2];
  logic signed [GAIN_W+ERR_W-1:0]  prod_d [2];
  logic signed [GAIN_W+SUM_W-1:0]  prod_i [2];
  logic signed [GAIN_W+HALF_W-1:0] prod_f [2];
  logic signed [PROD_W-1:0]        pp3 [2];
  logic signed [PROD_W-1:0]        pd3 [2];
  logic signed [PROD_W-1:0]        pi3 [2];
  logic signed [PROD_W-1:0]        pf3 [2];
  logic signed [POS_W-1:0]         pos3 [2];

  always_comb begin
    for (int c = 0; c < 2; c++) begin
      prod_p[c] = prop_gain * err2[c];
      prod_d[c] = deriv_gain_over_dt * dten2[c];
      prod_i[c] = integ_gain_dt * sum2[c];
      prod_f[c] = follow_gain * half2[c];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (rdy3) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (v2 && rdy3) begin
      for (int c = 0; c < 2; c++) begin
        pp3[c]  <= PROD_W'(prod_p[c]);
        pd3[c]  <= PROD_W'(prod_d[c]);
        pi3[c]  <= PROD_W'(prod_i[c]);
        pf3[c]  <= PROD_W'(prod_f[c]);
        pos3[c] <= pos2[c];
      end
    end
  end

  // Stage 4: PID and slave sums with the motor direction applied
  logic signed [ACC_W-1:0] acc_c  [4];
  logic signed [ACC_W-1:0] sacc_c [4];
  logic signed [ACC_W-1:0] sacc4  [4];
  logic signed [POS_W-1:0] base4  [4];

  always_comb begin
    for (int c = 0; c < 2; c++) begin
      acc_c[c]   = ACC_W'(pp3[c]) + ACC_W'(pd3[c]) + ACC_W'(pi3[c]);
      acc_c[c+2] = ACC_W'(pf3[c]) + (ACC_W'(pull_offset) <<< FRAC_W);
    end
    for (int m = 0; m < 4; m++) begin
      sacc_c[m] = direction_bits[m] ? -acc_c[m] : acc_c[m];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (rdy4) begin
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (v3 && rdy4) begin
      for (int m = 0; m < 4; m++) begin
        sacc4[m] <= sacc_c[m];
      end
      base4[0] <= pos3[0];
      base4[1] <= pos3[1];
      base4[2] <= home_pos[btpc_pkg::DIR_S1];
      base4[3] <= home_pos[btpc_pkg::DIR_S2];
    end
  end

  // Stage 5: add the base position, scale down toward zero, saturate
  localparam logic signed [FIN_W-1:0] ROUND_ADD = FIN_W'((1 << FRAC_W) - 1);
  localparam logic signed [FIN_W-1:0] POS_MAX   = (FIN_W'(1) <<< (POS_W - 1)) - FIN_W'(1);
  localparam logic signed [FIN_W-1:0] POS_MIN   = -(FIN_W'(1) <<< (POS_W - 1));

  logic signed [FIN_W-1:0] fin_sum [4];
  logic signed [FIN_W-1:0] fin_q   [4];
  logic signed [FIN_W-1:0] fin_sat [4];
  logic signed [OUT_W-1:0] cmd     [4];

  always_comb begin
    for (int m = 0; m < 4; m++) begin
      fin_sum[m] = FIN_W'(sacc4[m]) + (FIN_W'(base4[m]) <<< FRAC_W);
      fin_q[m]   = fin_sum[m][FIN_W-1] ? ((fin_sum[m] + ROUND_ADD) >>> FRAC_W)
                                       : (fin_sum[m] >>> FRAC_W);
      if (fin_q[m] > POS_MAX) begin
        fin_sat[m] = POS_MAX;
      end else if (fin_q[m] < POS_MIN) begin
        fin_sat[m] = POS_MIN;
      end else begin
        fin_sat[m] = fin_q[m];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else if (rdy5) begin
      v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (v4 && rdy5) begin
      for (int m = 0; m < 4; m++) begin
        cmd[m] <= fin_sat[m][OUT_W-1:0];
      end
    end
  end

  // Output packing, master one in the lowest bits
  always_comb begin
    m_tdata = '0;
    for (int m = 0; m < 4; m++) begin
      m_tdata[m*OUT_W +: OUT_W] = cmd[m];
    end
  end

  // A command set can only exist once home positions have been captured.
  a_out_after_start: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> started)
    else $error("command set presented before the first tick was captured");

  // With the result register empty, no stage may hold the input back.
  a_ready_when_drained: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled while the result register is empty");

  // The start flag is only set by a tick leaving the input register.
  a_start_by_tick: assert property (@(posedge clk) disable iff (rst)
    $rose(started) |-> $past(v1 && rdy2))
    else $error("start flag set without a tick");

endmodule
